>>> rtl/qrps_pkg.sv
// shared types, constants and fixed-point helpers for the propulsion step
package qrps_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;

  typedef logic signed [31:0] q_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_CT2  = 3'd0,
    REG_CT1  = 3'd1,
    REG_CT0  = 3'd2,
    REG_ARM  = 3'd3,
    REG_KT   = 3'd4,
    REG_FLUX = 3'd5,
    REG_INVR = 3'd6,
    REG_SOI  = 3'd7
  } reg_idx_t;

  // coefficients that every lane needs
  typedef struct packed {
    q_t ct2;
    q_t ct1;
    q_t ct0;
    q_t kt;
    q_t flux;
    q_t invr;
    q_t soi;
    q_t gain;
  } lane_cfg_t;

  // clamp a 34-bit value to 32 bits
  function automatic q_t sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // q16.16 product scaled back, arithmetic shift floors toward minus infinity
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [47:0] s;
    p = a * b;
    s = p[63:16];
    if (s > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -48'sh0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat34(34'(a) - 34'(b));
  endfunction

endpackage

>>> rtl/qrps_lane.sv
// one rotor lane: thrust, euler step of the motor speed, current and torque
module qrps_lane
  import qrps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lane_cfg_t cfg,
  input  q_t        inflow,
  input  q_t        voltage,
  output q_t        thrust,
  output q_t        speed,
  output q_t        current,
  output q_t        etorque,
  output logic      done
);

  // one multiply per cycle; the step counter drives which product is formed
  typedef enum logic [3:0] {
    S_IDLE, S_VV, S_VX, S_XX, S_Q, S_C, S_S, S_FX, S_LD, S_GD,
    S_A, S_DX, S_REM, S_OUT
  } st_t;

  st_t st_r;
  q_t  x_r;
  q_t  t0_r, t1_r, t2_r;
  q_t  f_r, d_r, a_r, rem_r, cur_r, et_r;
  logic done_r;

  q_t  ma, mb, prod;

  always_comb begin
    ma = inflow;
    mb = inflow;
    case (st_r)
      S_VV:    begin ma = inflow;    mb = inflow;  end
      S_VX:    begin ma = inflow;    mb = x_r;     end
      S_XX:    begin ma = x_r;       mb = x_r;     end
      S_Q:     begin ma = cfg.ct2;   mb = t0_r;    end
      S_C:     begin ma = cfg.ct1;   mb = t1_r;    end
      S_S:     begin ma = cfg.ct0;   mb = t2_r;    end
      S_FX:    begin ma = cfg.flux;  mb = x_r;     end
      S_LD:    begin ma = cfg.kt;    mb = f_r;     end
      S_GD:    begin ma = cfg.gain;  mb = d_r;     end
      S_A:     begin ma = cfg.soi;   mb = a_r;     end
      S_DX:    begin ma = cfg.flux;  mb = x_r;     end
      S_REM:   begin ma = cfg.gain;  mb = rem_r;   end
      S_OUT:   begin ma = cfg.invr;  mb = rem_r;   end
      default: begin ma = inflow;    mb = inflow;  end
    endcase
    prod = qmul(ma, mb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      x_r    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: if (start) st_r <= S_VV;
        S_VV:  begin t0_r <= prod; st_r <= S_VX; end
        S_VX:  begin t1_r <= prod; st_r <= S_XX; end
        S_XX:  begin t2_r <= prod; st_r <= S_Q;  end
        S_Q: begin
          // negated when the inflow is not negative
          t0_r <= inflow[31] ? prod : qsub('0, prod);
          st_r <= S_C;
        end
        S_C:   begin t1_r <= prod; st_r <= S_S; end
        S_S: begin
          f_r  <= sat34(34'(t0_r) + 34'(t1_r) + 34'(prod));
          st_r <= S_FX;
        end
        S_FX:  begin d_r <= qsub(voltage, prod); st_r <= S_LD; end
        S_LD:  begin t0_r <= prod; st_r <= S_GD; end
        S_GD:  begin a_r <= qsub(prod, t0_r); st_r <= S_A; end
        S_A:   begin x_r <= qadd(x_r, prod); st_r <= S_DX; end
        S_DX:  begin rem_r <= qsub(voltage, prod); st_r <= S_REM; end
        S_REM: begin et_r <= prod; st_r <= S_OUT; end
        S_OUT: begin cur_r <= prod; done_r <= 1'b1; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign thrust  = f_r;
  assign speed   = x_r;
  assign current = cur_r;
  assign etorque = et_r;
  assign done    = done_r;

endmodule

>>> rtl/qrps_merge.sv
// merging stage: total thrust, roll, pitch and yaw torques
module qrps_merge
  import qrps_pkg::*;
(
  input  logic clk,
  input  logic start,
  input  q_t   arm,
  input  q_t   f0, f1, f2, f3,
  input  q_t   e0, e1, e2, e3,
  output q_t   thrust_total,
  output q_t   roll_torque,
  output q_t   pitch_torque,
  output q_t   yaw_torque
);

  q_t tot_r, roll_r, pitch_r, yaw_r;

  always_ff @(posedge clk) begin
    if (start) begin
      tot_r   <= sat34(34'(f0) + 34'(f1) + 34'(f2) + 34'(f3));
      roll_r  <= qmul(qsub(f3, f1), arm);
      pitch_r <= qmul(qsub(f0, f2), arm);
      yaw_r   <= sat34(34'(e1) + 34'(e3) - 34'(e0) - 34'(e2));
    end
  end

  assign thrust_total = tot_r;
  assign roll_torque  = roll_r;
  assign pitch_torque = pitch_r;
  assign yaw_torque   = yaw_r;

endmodule

>>> rtl/quad_rotor_propulsion_step_top.sv
// top level of the quadrotor propulsion step
// one transaction is one simulation step for four dc motors. four identical lanes run
// side by side, one per rotor, each with a single shared q16.16 multiplier that it
// steps through 13 products. a step runs from input acceptance through the arm
// products and the inflow, the registered start to the lanes, the lane products,
// the lane done flag, the merging stage and the load of the output register. the
// block is ready for the next input in the cycle after the load. one step is in
// flight at a time because each step needs the speeds the previous one left; a new
// input is taken once the result has moved to the output register, even if that
// register still waits for the downstream side. the user writes configuration only
// while the block is idle; the block itself does not enforce this. configuration
// takes effect on the next step.
module quad_rotor_propulsion_step_top
  import qrps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertical_velocity, roll_rate, pitch_rate, drive_voltage_0..3
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // thrust_total, roll_torque, pitch_torque, yaw_torque, new_speed_0..3, current_0..3
  output logic [383:0] out_tdata
);

  typedef enum logic [2:0] {T_IDLE, T_ARM, T_FLOW, T_LANE, T_MERGE, T_LOAD} top_st_t;

  q_t        regs_r [NumRegs];
  q_t        gain_r;
  top_st_t   st_r;
  q_t        w_r, p_r, q_r, armp_r, armq_r;
  q_t        u_r [NumMotors];
  q_t        flow_r [NumMotors];
  logic      ovalid_r;
  logic [383:0] odata_r;
  logic      out_load;
  lane_cfg_t lcfg;
  logic      lane_start;
  logic [NumMotors-1:0] lane_done;
  q_t        f [NumMotors];
  q_t        spd [NumMotors];
  q_t        cur [NumMotors];
  q_t        et [NumMotors];
  q_t        tot, roll, pitch, yaw;

  // configuration registers, gain kept alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) regs_r[i] <= '0;
      gain_r <= '0;
    end else begin
      if (cfg_we) regs_r[cfg_index] <= cfg_data;
      gain_r <= qmul(regs_r[REG_FLUX], regs_r[REG_INVR]);
    end
  end

  assign lcfg = '{ct2: regs_r[REG_CT2], ct1: regs_r[REG_CT1], ct0: regs_r[REG_CT0],
                  kt: regs_r[REG_KT], flux: regs_r[REG_FLUX], invr: regs_r[REG_INVR],
                  soi: regs_r[REG_SOI], gain: gain_r};

  // a new step may enter once the output register holds the previous one
  assign in_tready  = (st_r == T_IDLE);
  assign lane_start = (st_r == T_FLOW);

  // the finished step moves to the output register once that register is free
  assign out_load = (st_r == T_LOAD) && (!ovalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= T_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        T_IDLE: if (in_tvalid) begin
          w_r <= in_tdata[31:0];
          p_r <= in_tdata[63:32];
          q_r <= in_tdata[95:64];
          for (int i = 0; i < NumMotors; i++) u_r[i] <= in_tdata[96+32*i +: 32];
          st_r <= T_ARM;
        end
        T_ARM: begin
          armp_r <= qmul(regs_r[REG_ARM], p_r);
          armq_r <= qmul(regs_r[REG_ARM], q_r);
          st_r   <= T_FLOW;
        end
        T_FLOW: begin
          flow_r[0] <= sat34(-34'(w_r) + 34'(armq_r));
          flow_r[1] <= sat34(-34'(w_r) - 34'(armp_r));
          flow_r[2] <= sat34(-34'(w_r) - 34'(armq_r));
          flow_r[3] <= sat34(-34'(w_r) + 34'(armp_r));
          st_r <= T_LANE;
        end
        T_LANE:  if (&lane_done) st_r <= T_MERGE;
        T_MERGE: st_r <= T_LOAD;
        T_LOAD: begin
          // wait until the output register is free
          if (out_load) begin
            odata_r <= {cur[3], cur[2], cur[1], cur[0], spd[3], spd[2], spd[1], spd[0],
                        yaw, pitch, roll, tot};
            st_r    <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  // lanes take their inflow in the cycle after it is formed
  logic lane_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) lane_go_r <= 1'b0;
    else        lane_go_r <= lane_start;
  end

  for (genvar g = 0; g < NumMotors; g++) begin : g_lane
    qrps_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(lane_go_r), .cfg(lcfg),
      .inflow(flow_r[g]), .voltage(u_r[g]),
      .thrust(f[g]), .speed(spd[g]), .current(cur[g]), .etorque(et[g]),
      .done(lane_done[g])
    );
  end

  qrps_merge u_merge (
    .clk(clk), .start(st_r == T_MERGE), .arm(regs_r[REG_ARM]),
    .f0(f[0]), .f1(f[1]), .f2(f[2]), .f3(f[3]),
    .e0(et[0]), .e1(et[1]), .e2(et[2]), .e3(et[3]),
    .thrust_total(tot), .roll_torque(roll), .pitch_torque(pitch), .yaw_torque(yaw)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

>>> rtl/qrps_checker.sv
// port-level checks for the propulsion step, bound to the top level
module qrps_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [383:0] out_tdata
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  // no new step straight after one is accepted
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second step accepted during work");

  // a result never appears the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

endmodule

bind quad_rotor_propulsion_step_top qrps_checker u_qrps_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
